// ===== rtl/core/rotation_matrix_to_quaternion_assert.svh =====
// assertion macros for the rotation matrix to quaternion block
// no dependencies; included by the top level
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTH
`define RMQ_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/rmq_pkg.sv =====
// widths, types and helpers for the rotation matrix to quaternion block
// no dependencies
`timescale 1ns / 1ps
package rmq_pkg;
    localparam int DW   = 16;
    localparam int FB   = 14;
    localparam int TW   = ((FB + 2 > DW + 2) ? FB + 2 : DW + 2) + 1;
    localparam int RADW = TW - 1 + FB;
    localparam int RADE = RADW + (RADW % 2);
    localparam int RW   = RADE / 2;
    localparam int NW   = DW + 2;
    localparam int MW   = DW + 1;
    localparam int SW   = RW + 1;
    localparam int DVW  = ((MW + FB > RW) ? MW + FB : RW) + 1;
    localparam int QW   = DVW;

    localparam logic signed [TW-1:0] ONE = TW'(1) << FB;
    localparam logic signed [QW:0] SAT_HI = (QW + 1)'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic signed [QW:0] SAT_LO = -SAT_HI - (QW + 1)'(1);

    typedef enum logic [1:0] {
        SEL_TRACE = 2'd0,
        SEL_X     = 2'd1,
        SEL_Y     = 2'd2,
        SEL_Z     = 2'd3
    } sel_t;

    typedef struct packed {
        sel_t                   sel;
        logic                   degen;
        logic [RADE-1:0]        rad;
        logic signed [NW-1:0]   n0;
        logic signed [NW-1:0]   n1;
        logic signed [NW-1:0]   n2;
    } sq_side_t;

    typedef struct packed {
        sel_t            sel;
        logic            degen;
        logic [2:0]      neg;
        logic [RW-1:0]   mainc;
        logic [SW-1:0]   divisor;
    } dv_side_t;

    function automatic logic signed [DW-1:0] sat(input logic signed [QW:0] v);
        logic signed [QW:0] c;
        begin
            c = v;
            if (v > SAT_HI)
            begin
                c = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                c = SAT_LO;
            end
            return c[DW-1:0];
        end
    endfunction
endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// top level: rotation matrix to quaternion, shepperd branch selection
// depends on rmq_pkg, rmq_select, rmq_sqrt_cell, rmq_div_cell, assert header
//
//   channel   handshake               beat fields
//   item      item_valid/item_stall   m11 m12 m13 m21 m22 m23 m31 m32 m33
//   quat      quat_valid/quat_stall   qx qy qz qw case_taken degenerate
//
// one beat enters per cycle while the chain advances; the chain holds:
// one select stage, one square root cell per root bit, one divider cell per
// quotient bit (three lanes), one output register
// reset clears only the valid bits along the chain
// the whole chain advances together; it halts only while the output beat
// is held by quat_stall, and item_stall mirrors that hold
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic signed [DW-1:0] m11,
    input  logic signed [DW-1:0] m12,
    input  logic signed [DW-1:0] m13,
    input  logic signed [DW-1:0] m21,
    input  logic signed [DW-1:0] m22,
    input  logic signed [DW-1:0] m23,
    input  logic signed [DW-1:0] m31,
    input  logic signed [DW-1:0] m32,
    input  logic signed [DW-1:0] m33,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output logic signed [DW-1:0] qx,
    output logic signed [DW-1:0] qy,
    output logic signed [DW-1:0] qz,
    output logic signed [DW-1:0] qw,
    output logic [1:0]           case_taken,
    output logic                 degenerate
);
    logic adv;
    logic out_vld_reg;

    // chain advances unless the output beat is stuck
    assign adv = !(out_vld_reg && quat_stall);
    assign item_stall = !adv;

    // ---------------- select stage ----------------
    logic     sel_vld;
    sq_side_t sel_side;

    rmq_select u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (item_valid),
        .m11     (m11),
        .m12     (m12),
        .m13     (m13),
        .m21     (m21),
        .m22     (m22),
        .m23     (m23),
        .m31     (m31),
        .m32     (m32),
        .m33     (m33),
        .out_vld (sel_vld),
        .side    (sel_side)
    );

    // ---------------- square root chain ----------------
    logic [RW+1:0]   sq_rem  [0:RW];
    logic [RW-1:0]   sq_root [0:RW];
    logic [RADE-1:0] sq_rad  [0:RW];
    logic            sq_vld  [0:RW];
    sq_side_t        sq_side [0:RW];
    logic            sq_vld_reg  [0:RW-1];
    sq_side_t        sq_side_reg [0:RW-1];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = sel_side.rad;
    assign sq_vld[0]  = sel_vld;
    assign sq_side[0] = sel_side;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_in   (sq_rad[k]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .rad_out  (sq_rad[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[k] <= sq_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= sq_side[k];
            end
        end

        assign sq_vld[k+1]  = sq_vld_reg[k];
        assign sq_side[k+1] = sq_side_reg[k];
    end

    // ---------------- divider setup ----------------
    // dividend is |n| * 2^FB + r so the quotient by 2r rounds half away
    logic [RW-1:0]        root;
    sq_side_t             sqo;
    logic signed [NW-1:0] nsel [0:2];
    logic [MW-1:0]        nmag [0:2];
    logic [DVW-1:0]       dvd0 [0:2];
    dv_side_t             dv_head;

    assign root = sq_root[RW];
    assign sqo  = sq_side[RW];
    assign nsel[0] = sqo.n0;
    assign nsel[1] = sqo.n1;
    assign nsel[2] = sqo.n2;

    always_comb
    begin
        dv_head.sel     = sqo.sel;
        dv_head.degen   = sqo.degen;
        dv_head.mainc   = RW'((SW'(root) + SW'(1)) >> 1);
        dv_head.divisor = {root, 1'b0};
        for (int j = 0; j < 3; j++)
        begin
            dv_head.neg[j] = nsel[j][NW-1];
            nmag[j] = nsel[j][NW-1] ? MW'(-nsel[j]) : MW'(nsel[j]);
            dvd0[j] = (DVW'(nmag[j]) << FB) + DVW'(root);
        end
    end

    // ---------------- divider chain, three lanes ----------------
    logic [SW:0]    dv_rem [0:2][0:QW];
    logic [DVW-1:0] dv_dvd [0:2][0:QW];
    logic [QW-1:0]  dv_q   [0:2][0:QW];
    logic           dv_vld [0:QW];
    dv_side_t       dv_side [0:QW];
    logic           dv_vld_reg  [0:QW-1];
    dv_side_t       dv_side_reg [0:QW-1];

    assign dv_vld[0]  = sq_vld[RW];
    assign dv_side[0] = dv_head;

    for (genvar ln = 0; ln < 3; ln++)
    begin : g_lane
        assign dv_rem[ln][0] = '0;
        assign dv_dvd[ln][0] = dvd0[ln];
        assign dv_q[ln][0]   = '0;
        for (genvar k = 0; k < QW; k++)
        begin : g_div
            rmq_div_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .divisor (dv_side[k].divisor),
                .rem_in  (dv_rem[ln][k]),
                .dvd_in  (dv_dvd[ln][k]),
                .q_in    (dv_q[ln][k]),
                .rem_out (dv_rem[ln][k+1]),
                .dvd_out (dv_dvd[ln][k+1]),
                .q_out   (dv_q[ln][k+1])
            );
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_dvside
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[k] <= dv_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[k] <= dv_side[k];
            end
        end

        assign dv_vld[k+1]  = dv_vld_reg[k];
        assign dv_side[k+1] = dv_side_reg[k];
    end

    // ---------------- sign, saturation, component placement ----------------
    dv_side_t              fin;
    logic signed [QW:0]    qs [0:2];
    logic signed [DW-1:0]  ca, cb, cc, cm;
    logic signed [DW-1:0]  qx_next, qy_next, qz_next, qw_next;
    logic signed [DW-1:0]  qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]            case_reg;
    logic                  degen_reg;

    assign fin = dv_side[QW];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qs[j] = fin.neg[j] ? -$signed({1'b0, dv_q[j][QW]}) : $signed({1'b0, dv_q[j][QW]});
        end
        ca = sat(qs[0]);
        cb = sat(qs[1]);
        cc = sat(qs[2]);
        cm = sat((QW + 1)'(fin.mainc));
        case (fin.sel)
            SEL_TRACE:
            begin
                qx_next = ca; qy_next = cb; qz_next = cc; qw_next = cm;
            end
            SEL_X:
            begin
                qx_next = cm; qy_next = ca; qz_next = cb; qw_next = cc;
            end
            SEL_Y:
            begin
                qx_next = ca; qy_next = cm; qz_next = cb; qw_next = cc;
            end
            default:
            begin
                qx_next = ca; qy_next = cb; qz_next = cm; qw_next = cc;
            end
        endcase
        if (fin.degen)
        begin
            qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            qz_reg    <= qz_next;
            qw_reg    <= qw_next;
            case_reg  <= fin.sel;
            degen_reg <= fin.degen;
        end
    end

    assign quat_valid = out_vld_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign qw         = qw_reg;
    assign case_taken = case_reg;
    assign degenerate = degen_reg;

    // ---------------- checks ----------------
    `RMQ_ASSERT_NOW(a_degen_zero, clk, rst_n, quat_valid && degenerate, qx == 0 && qy == 0 && qz == 0 && qw == 0)
    `RMQ_ASSERT_NOW(a_trace_not_degen, clk, rst_n, quat_valid && case_taken == SEL_TRACE, !degenerate)
    `RMQ_ASSERT_NOW(a_stall_from_output, clk, rst_n, item_stall, quat_valid && quat_stall)
    `RMQ_ASSERT_NEXT(a_drain_empty, clk, rst_n, quat_valid && !quat_stall && !dv_vld[QW], !quat_valid)
endmodule

// ===== rtl/core/rmq_select.sv =====
// branch selection stage: picks the case, forms the radicand and numerators
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_select import rmq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [DW-1:0] m11,
    input  logic signed [DW-1:0] m12,
    input  logic signed [DW-1:0] m13,
    input  logic signed [DW-1:0] m21,
    input  logic signed [DW-1:0] m22,
    input  logic signed [DW-1:0] m23,
    input  logic signed [DW-1:0] m31,
    input  logic signed [DW-1:0] m32,
    input  logic signed [DW-1:0] m33,
    output logic                 out_vld,
    output sq_side_t             side
);
    logic signed [TW-1:0] a11, a22, a33, trace, t;
    sq_side_t side_next, side_reg;
    logic vld_reg;

    always_comb
    begin
        a11 = TW'(m11);
        a22 = TW'(m22);
        a33 = TW'(m33);
        trace = a11 + a22 + a33;
        side_next = '0;
        if (trace > 0)
        begin
            side_next.sel = SEL_TRACE;
            t = ONE + trace;
            side_next.n0 = NW'(m32) - NW'(m23);
            side_next.n1 = NW'(m13) - NW'(m31);
            side_next.n2 = NW'(m21) - NW'(m12);
        end
        else if (m11 > m22 && m11 > m33)
        begin
            side_next.sel = SEL_X;
            t = ONE + a11 - a22 - a33;
            side_next.n0 = NW'(m12) + NW'(m21);
            side_next.n1 = NW'(m13) + NW'(m31);
            side_next.n2 = NW'(m32) - NW'(m23);
        end
        else if (m22 > m33)
        begin
            side_next.sel = SEL_Y;
            t = ONE + a22 - a11 - a33;
            side_next.n0 = NW'(m12) + NW'(m21);
            side_next.n1 = NW'(m23) + NW'(m32);
            side_next.n2 = NW'(m13) - NW'(m31);
        end
        else
        begin
            side_next.sel = SEL_Z;
            t = ONE + a33 - a11 - a22;
            side_next.n0 = NW'(m13) + NW'(m31);
            side_next.n1 = NW'(m23) + NW'(m32);
            side_next.n2 = NW'(m21) - NW'(m12);
        end
        side_next.degen = (t <= 0);
        side_next.rad = side_next.degen ? '0 : (RADE'(t[TW-2:0]) << FB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
        end
    end

    assign out_vld = vld_reg;
    assign side    = side_reg;
endmodule

// ===== rtl/core/rmq_sqrt_cell.sv =====
// one root bit of the restoring square root chain
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_sqrt_cell import rmq_pkg::*; (
    input  logic            clk,
    input  logic            en,
    input  logic [RW+1:0]   rem_in,
    input  logic [RW-1:0]   root_in,
    input  logic [RADE-1:0] rad_in,
    output logic [RW+1:0]   rem_out,
    output logic [RW-1:0]   root_out,
    output logic [RADE-1:0] rad_out
);
    logic [RW+3:0] rem_sh, trial;
    logic [RW+1:0] rem_next, rem_reg;
    logic [RW-1:0] root_next, root_reg;
    logic [RADE-1:0] rad_reg;
    logic take;

    always_comb
    begin
        rem_sh = {rem_in, rad_in[RADE-1 -: 2]};
        trial  = {2'b00, root_in, 2'b01};
        take   = (rem_sh >= trial);
        rem_next  = take ? (RW + 2)'(rem_sh - trial) : rem_sh[RW+1:0];
        root_next = {root_in[RW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_in << 2;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
endmodule

// ===== rtl/core/rmq_div_cell.sv =====
// one quotient bit of the restoring divider chain
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_div_cell import rmq_pkg::*; (
    input  logic           clk,
    input  logic           en,
    input  logic [SW-1:0]  divisor,
    input  logic [SW:0]    rem_in,
    input  logic [DVW-1:0] dvd_in,
    input  logic [QW-1:0]  q_in,
    output logic [SW:0]    rem_out,
    output logic [DVW-1:0] dvd_out,
    output logic [QW-1:0]  q_out
);
    logic [SW:0] rem_sh, rem_reg;
    logic [DVW-1:0] dvd_reg;
    logic [QW-1:0] q_reg;
    logic take;

    always_comb
    begin
        rem_sh = {rem_in[SW-1:0], dvd_in[DVW-1]};
        take   = (rem_sh >= {1'b0, divisor});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= take ? (rem_sh - {1'b0, divisor}) : rem_sh;
            dvd_reg <= dvd_in << 1;
            q_reg   <= {q_in[QW-2:0], take};
        end
    end

    assign rem_out = rem_reg;
    assign dvd_out = dvd_reg;
    assign q_out   = q_reg;
endmodule
